// ===== design/twtp_pkg.sv =====
// ----------------------------------------------------------------------------
// twtp_pkg
// Shared types and constants for the hashed timing wheel timer pool.
// ----------------------------------------------------------------------------
package twtp_pkg;

    // fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int TIMEOUT_W  = 32;
    localparam int HANDLE_W   = 5;
    localparam int OUT_SLOT_W = 6;
    localparam int ROT_W      = 26;
    localparam int STATUS_W   = 3;

    // cell index width, enough for the largest pool
    localparam int HIDX_W = 6;

    // a non-negative timeout has this many magnitude bits
    localparam int DIVIDEND_W = TIMEOUT_W - 1;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam logic [ROT_W-1:0] ROT_MAX = '1;

    // operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_NEG     = 3'd1,
        ST_FULL    = 3'd2,
        ST_DEL     = 3'd3,
        ST_DEL_IGN = 3'd4,
        ST_EXPIRED = 3'd5,
        ST_DONE    = 3'd6
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_TICK
    } t_state;

    // input transaction payload
    typedef struct packed {
        logic [OPCODE_W-1:0]         opcode;
        logic signed [TIMEOUT_W-1:0] timeout;
        logic [HANDLE_W-1:0]         handle;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle_res;
        logic [OUT_SLOT_W-1:0] slot;
        logic [ROT_W-1:0]      rotation;
        logic                  last;
    } t_out_item;

    // commands broadcast from the controller to the cell row
    typedef struct packed {
        logic step;    // token holder passes the token on
        logic drop;    // token holder discards the token
        logic write;   // token holder stores a new timer
        logic expire;  // token holder frees its timer
        logic dec;     // token holder counts one rotation down
        logic del;     // addressed cell frees its timer
    } t_cell_cmd;

    // report of the cell that holds the token (all zero elsewhere)
    typedef struct packed {
        logic              tok;
        logic              valid;
        logic              match;
        logic              zero;
        logic [HIDX_W-1:0] idx;
    } t_cell_rep;

endpackage

// ===== design/twtp_if.sv =====
// ----------------------------------------------------------------------------
// twtp_in_if / twtp_out_if
// Valid/ready channels carrying the operation and result transactions.
// ----------------------------------------------------------------------------
interface twtp_in_if import twtp_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface twtp_out_if import twtp_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/twtp_cell.sv =====
// ----------------------------------------------------------------------------
// twtp_cell
// One timer entry of the pool. A scan token travels along the row of cells;
// the cell that holds it reports its entry and obeys the broadcast command.
// ----------------------------------------------------------------------------
module twtp_cell import twtp_pkg::*; #(
    parameter int SLOT_W = 6,
    parameter int IDX    = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok,
    output logic                o_tok,
    input  t_cell_cmd           i_cmd,
    input  logic [SLOT_W-1:0]   i_cur_slot,
    input  logic [SLOT_W-1:0]   i_wr_slot,
    input  logic [ROT_W-1:0]    i_wr_rounds,
    input  logic [HANDLE_W-1:0] i_del_handle,
    output t_cell_rep           o_rep,
    output logic                o_del_hit
);

    localparam logic [HIDX_W-1:0] MY_IDX = HIDX_W'(IDX);

    logic              r_tok;
    logic              r_valid;
    logic [SLOT_W-1:0] r_slot;
    logic [ROT_W-1:0]  r_rounds;
    logic              n_tok;
    logic              n_valid;
    logic              addressed;

    // direct addressing for delete
    assign addressed = ({1'b0, i_del_handle} == MY_IDX);
    assign o_del_hit = r_valid & addressed;

    // token hand-over to the right-hand neighbour
    assign o_tok = r_tok & i_cmd.step;
    assign n_tok = i_tok | (r_tok & ~i_cmd.step & ~i_cmd.drop);

    // entry state update
    always_comb begin
        n_valid = r_valid;
        if (r_tok && i_cmd.write) begin
            n_valid = 1'b1;
        end else if (r_tok && i_cmd.expire) begin
            n_valid = 1'b0;
        end else if (i_cmd.del && addressed) begin
            n_valid = 1'b0;
        end
    end

    // report, only from the token holder
    always_comb begin
        o_rep.tok   = r_tok;
        o_rep.valid = r_tok & r_valid;
        o_rep.match = r_tok & (r_slot == i_cur_slot);
        o_rep.zero  = r_tok & (r_rounds == '0);
        o_rep.idx   = r_tok ? MY_IDX : '0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tok   <= n_tok;
            r_valid <= n_valid;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (r_tok && i_cmd.write) begin
            r_slot   <= i_wr_slot;
            r_rounds <= i_wr_rounds;
        end else if (r_tok && i_cmd.dec) begin
            r_rounds <= r_rounds - ROT_W'(1);
        end
    end

endmodule

// ===== design/twtp_div.sv =====
// ----------------------------------------------------------------------------
// twtp_div
// Four-stage constant divider: timeout / tick units gives the tick count, and
// tick count / slot count gives rotation and slot offset. Each division uses
// reciprocal multiplication followed by a one-step remainder fix-up.
// ----------------------------------------------------------------------------
module twtp_div import twtp_pkg::*; #(
    parameter int TICK_UNITS = 1,
    parameter int SLOTS      = 60,
    localparam int SLOT_W    = $clog2(SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_busy,
    output logic [SLOT_W-1:0]     o_slot_off,
    output logic [ROT_W-1:0]      o_rot
);

    // reciprocals scaled by 2^FRAC_SH; the estimate is low by at most one
    localparam int FRAC_SH = 32;
    localparam int RECIP_W = FRAC_SH + 1;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_A = RECIP_W'((64'd1 << FRAC_SH) / TICK_UNITS);
    localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'((64'd1 << FRAC_SH) / SLOTS);
    localparam logic [DIVIDEND_W-1:0] DIV_A = DIVIDEND_W'(TICK_UNITS);
    localparam logic [DIVIDEND_W-1:0] DIV_B = DIVIDEND_W'(SLOTS);

    logic [3:0]            r_stg;
    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVIDEND_W-1:0] r_qa;
    logic [DIVIDEND_W-1:0] r_ticks;
    logic [DIVIDEND_W-1:0] r_qb;
    logic [SLOT_W-1:0]     r_off;
    logic [ROT_W-1:0]      r_rot;

    logic [PROD_W-1:0]     prod_a;
    logic [DIVIDEND_W-1:0] rem_a;
    logic [DIVIDEND_W-1:0] quo_a;
    logic [DIVIDEND_W-1:0] ticks;
    logic [PROD_W-1:0]     prod_b;
    logic [DIVIDEND_W-1:0] rem_b;
    logic [DIVIDEND_W-1:0] quo_b;
    logic [DIVIDEND_W-1:0] off_b;

    // quotient estimates from the reciprocals
    always_comb begin
        prod_a = PROD_W'(r_num) * PROD_W'(RECIP_A);
        prod_b = PROD_W'(r_ticks) * PROD_W'(RECIP_B);
    end

    // remainder check lifts a low estimate by one
    always_comb begin
        rem_a = r_num - r_qa * DIV_A;
        quo_a = (rem_a >= DIV_A) ? r_qa + DIVIDEND_W'(1) : r_qa;
        // a zero tick count stands for one tick
        ticks = (quo_a == '0) ? DIVIDEND_W'(1) : quo_a;
        rem_b = r_ticks - r_qb * DIV_B;
        if (rem_b >= DIV_B) begin
            quo_b = r_qb + DIVIDEND_W'(1);
            off_b = rem_b - DIV_B;
        end else begin
            quo_b = r_qb;
            off_b = rem_b;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[2:0], i_start};
        end
    end

    // datapath, one stage per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
        end
        if (r_stg[0]) begin
            r_qa <= prod_a[FRAC_SH +: DIVIDEND_W];
        end
        if (r_stg[1]) begin
            r_ticks <= ticks;
        end
        if (r_stg[2]) begin
            r_qb <= prod_b[FRAC_SH +: DIVIDEND_W];
        end
        if (r_stg[3]) begin
            r_off <= off_b[SLOT_W-1:0];
            r_rot <= (quo_b > DIVIDEND_W'(ROT_MAX)) ? ROT_MAX : quo_b[ROT_W-1:0];
        end
    end

    assign o_busy     = |r_stg;
    assign o_slot_off = r_off;
    assign o_rot      = r_rot;

endmodule

// ===== design/timing_wheel_timer_pool.sv =====
// Add: the result waits for the four divider stages and for the scan token to
//   reach the lowest free handle, or to leave the cell row if the pool is full.
// Delete: result in the cycle after acceptance; one transaction per cycle
//   while the output is not stalled. Tick: the scan token moves along the cell
//   row one cell per cycle, waiting at an expiring cell while the output stalls.
// Reset is synchronous: all timers free, current slot zero, no clearing pass.
// ----------------------------------------------------------------------------
// timing_wheel_timer_pool
// Hashed timing wheel over a fixed pool of timer entries held in a row of
// cells; add, delete and tick transactions, expiries in ascending handle order.
// ----------------------------------------------------------------------------
module timing_wheel_timer_pool import twtp_pkg::*; #(
    parameter int SLOTS        = 60,
    parameter int TICK_UNITS   = 1,
    parameter int POOL_ENTRIES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twtp_in_if.sink    i_in,
    twtp_out_if.source o_out
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W:0] SLOTS_X = (SLOT_W + 1)'(SLOTS);

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_cur;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic out_ok;
    logic out_ld;
    logic in_ready;
    logic inject;
    logic div_start;
    logic cur_adv;

    t_cell_cmd cmd;
    t_cell_rep cell_rep [POOL_ENTRIES];
    t_cell_rep rep;
    logic      tok_in   [POOL_ENTRIES];
    logic      tok_out  [POOL_ENTRIES];
    logic      hit      [POOL_ENTRIES];
    logic      del_hit;

    logic                   div_busy;
    logic [SLOT_W-1:0]      div_off;
    logic [ROT_W-1:0]       div_rot;
    logic [SLOT_W:0]        slot_sum;
    logic [SLOT_W-1:0]      add_slot;
    logic [SLOT_W+OUT_SLOT_W-1:0] cur_ext;
    logic [SLOT_W+OUT_SLOT_W-1:0] add_ext;

    // pipelined constant divider for tick count, rotation and slot offset
    twtp_div #(
        .TICK_UNITS (TICK_UNITS),
        .SLOTS      (SLOTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.item.timeout[DIVIDEND_W-1:0]),
        .o_busy     (div_busy),
        .o_slot_off (div_off),
        .o_rot      (div_rot)
    );

    // target slot of a new timer
    always_comb begin
        slot_sum = {1'b0, r_cur} + {1'b0, div_off};
        if (slot_sum >= SLOTS_X) begin
            slot_sum = slot_sum - SLOTS_X;
        end
        add_slot = slot_sum[SLOT_W-1:0];
        cur_ext  = {{OUT_SLOT_W{1'b0}}, r_cur};
        add_ext  = {{OUT_SLOT_W{1'b0}}, add_slot};
    end

    // row of timer cells with the scan token chain
    for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign tok_in[g] = inject;
        end else begin : g_link
            assign tok_in[g] = tok_out[g-1];
        end

        twtp_cell #(
            .SLOT_W (SLOT_W),
            .IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (tok_in[g]),
            .o_tok        (tok_out[g]),
            .i_cmd        (cmd),
            .i_cur_slot   (r_cur),
            .i_wr_slot    (add_slot),
            .i_wr_rounds  (div_rot),
            .i_del_handle (i_in.item.handle),
            .o_rep        (cell_rep[g]),
            .o_del_hit    (hit[g])
        );
    end

    // only the token holder reports, so the reports merge by or
    always_comb begin
        rep     = '0;
        del_hit = 1'b0;
        for (int i = 0; i < POOL_ENTRIES; i++) begin
            rep     = rep | cell_rep[i];
            del_hit = del_hit | hit[i];
        end
    end

    assign out_ok = ~r_out_valid | o_out.ready;

    // next state, cell commands and results
    always_comb begin
        n_state   = r_state;
        n_out     = '0;
        out_ld    = 1'b0;
        in_ready  = 1'b0;
        inject    = 1'b0;
        div_start = 1'b0;
        cur_adv   = 1'b0;
        cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = out_ok;
                if (i_in.valid && out_ok) begin
                    unique case (i_in.item.opcode)
                        OP_ADD: begin
                            if (i_in.item.timeout[TIMEOUT_W-1]) begin
                                out_ld       = 1'b1;
                                n_out.status = ST_NEG;
                                n_out.last   = 1'b1;
                            end else begin
                                div_start = 1'b1;
                                inject    = 1'b1;
                                n_state   = S_ADD;
                            end
                        end
                        OP_DEL: begin
                            cmd.del          = 1'b1;
                            out_ld           = 1'b1;
                            n_out.status     = del_hit ? ST_DEL : ST_DEL_IGN;
                            n_out.handle_res = i_in.item.handle;
                            n_out.last       = 1'b1;
                        end
                        OP_TICK: begin
                            inject  = 1'b1;
                            n_state = S_TICK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                // token runs on past occupied cells and parks on the first free one
                cmd.step = rep.tok & rep.valid;
                if (!div_busy && (!rep.tok || !rep.valid) && out_ok) begin
                    out_ld     = 1'b1;
                    n_out.last = 1'b1;
                    n_state    = S_IDLE;
                    if (rep.tok) begin
                        cmd.write        = 1'b1;
                        cmd.drop         = 1'b1;
                        n_out.status     = ST_ADDED;
                        n_out.handle_res = rep.idx[HANDLE_W-1:0];
                        n_out.slot       = add_ext[OUT_SLOT_W-1:0];
                        n_out.rotation   = div_rot;
                    end else begin
                        n_out.status = ST_FULL;
                    end
                end
            end
            S_TICK: begin
                priority if (!rep.tok) begin
                    // scan finished
                    if (out_ok) begin
                        out_ld       = 1'b1;
                        n_out.status = ST_DONE;
                        n_out.slot   = cur_ext[OUT_SLOT_W-1:0];
                        n_out.last   = 1'b1;
                        cur_adv      = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (rep.valid && rep.match && !rep.zero) begin
                    cmd.dec  = 1'b1;
                    cmd.step = 1'b1;
                end else if (rep.valid && rep.match) begin
                    if (out_ok) begin
                        cmd.expire       = 1'b1;
                        cmd.step         = 1'b1;
                        out_ld           = 1'b1;
                        n_out.status     = ST_EXPIRED;
                        n_out.handle_res = rep.idx[HANDLE_W-1:0];
                        n_out.slot       = cur_ext[OUT_SLOT_W-1:0];
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // current slot of the wheel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (cur_adv) begin
            r_cur <= (r_cur == SLOT_W'(SLOTS - 1)) ? '0 : r_cur + SLOT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

endmodule

// ===== design/twtp_chk.sv =====
// ----------------------------------------------------------------------------
// twtp_chk
// Port-level checks of the timer pool transaction sequencing.
// ----------------------------------------------------------------------------
module twtp_chk import twtp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [OPCODE_W-1:0] i_in_opcode,
    input logic                i_in_neg,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input t_status             i_out_status,
    input logic                i_out_last
);

    logic in_fire;
    assign in_fire = i_in_valid & i_in_ready;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a delete answers in the next cycle with its single result
    a_del_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_opcode == OP_DEL |=>
            i_out_valid && i_out_last
            && (i_out_status == ST_DEL || i_out_status == ST_DEL_IGN))
        else $error("delete result missing or wrong");

    // a negative timeout is rejected at once
    a_neg_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_opcode == OP_ADD && i_in_neg |=>
            i_out_valid && i_out_last && i_out_status == ST_NEG)
        else $error("negative timeout not rejected");

    // only expiries are followed by more results
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_status == ST_EXPIRED)
        else $error("non-final result that is not an expiry");

    // a tick holds off new transactions while it scans
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_opcode == OP_TICK |=> !i_in_ready)
        else $error("transaction taken during a tick scan");

endmodule

bind timing_wheel_timer_pool twtp_chk u_twtp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_opcode  (i_in.item.opcode),
    .i_in_neg     (i_in.item.timeout[31]),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.item.status),
    .i_out_last   (o_out.item.last)
);
